### rtl/nbody_gravity_step_top_assert.svh
// Assertion macros shared by the n-body step block.
`ifndef NBODY_GRAVITY_STEP_TOP_ASSERT_SVH
`define NBODY_GRAVITY_STEP_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define NBGS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication.
`define NBGS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NBGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/nbgs_pkg.sv
// Types, constants and codes of the n-body gravity step block.
package nbgs_pkg;

    localparam int MAX_BODIES_DEF = 16;
    localparam int GRAV_CONST     = 200;
    localparam int EPS_Q16        = 66;
    localparam int SOFT_Q16       = 25 * 65536;
    localparam int ONE_Q16        = 65536;
    localparam logic [12:0] WIDTH_RESET  = 13'd800;
    localparam logic [12:0] HEIGHT_RESET = 13'd600;

    // register select, paddr bit 2
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_I, S_GET_I, S_LD_J, S_GET_J, S_SQX, S_SQY, S_SQRT,
        S_FORCE, S_UX, S_UY, S_AX, S_AY, S_ACC, S_VX, S_VY, S_VW,
        S_P_LD, S_P_GET, S_P_X, S_P_Y, S_P_OUT, S_MUL, S_DIV
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        mass;
        logic [16:0]        time_step;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         body_index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic               last;
    } out_item_t;

endpackage

### rtl/nbody_gravity_step_top.sv
// Top level of the n-body gravity step block: body table, sequencer and shared arithmetic.
//
// Input channel s_valid/s_ready/s_data carries commands: clear, add body, step, no-op.
// Clear, add and no-op give no result.
// A step on n bodies gives n result transactions on m_valid/m_ready/m_data, in index
// order, the last one flagged. s_ready is high only while the block is idle.
// A step visits every ordered body pair (n*(n-1) pairs) with a square root and three
// shift-subtract divisions each, then updates the velocities and positions of the bodies.
// One 32x32 multiplier is shared; every product takes two passes of it.
// Results leave through an output register; while the receiver holds m_ready low
// the sequencer waits on the current body and resumes when it is taken.
// Reset (aresetn low at a clock edge) empties the table, returns the sequencer to idle,
// drops m_valid and restores the screen sizes to 800 by 600. The APB port holds screen
// width at 0x0 and height at 0x4, to be written only while idle; this is not checked.
`include "nbody_gravity_step_top_assert.svh"

module nbody_gravity_step_top #(
    parameter int MAX_BODIES = nbgs_pkg::MAX_BODIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nbgs_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nbgs_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BODIES);

    function automatic logic [31:0] abs33(input logic [32:0] x);
        logic [32:0] n;
        n = x[32] ? (~x + 33'd1) : x;
        return n[31:0];
    endfunction

    function automatic logic [47:0] abs48(input logic [47:0] x);
        return x[47] ? (~x + 48'd1) : x;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -48'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // new velocity: v + trunc(a*dt / 2^16), product magnitude given
    function automatic logic [31:0] vel_upd(input logic [31:0] v, input logic neg,
                                            input logic [41:0] mag);
        logic signed [47:0] dv;
        logic signed [47:0] sum;
        dv  = neg ? -$signed({6'b0, mag}) : $signed({6'b0, mag});
        sum = $signed({{16{v[31]}}, v}) + dv;
        return sat32(sum);
    endfunction

    function automatic logic [31:0] wrap_pos(input logic [31:0] p, input logic neg,
                                             input logic [31:0] mag, input logic [12:0] size);
        logic signed [33:0] np;
        logic signed [33:0] lim;
        logic signed [33:0] dlt;
        lim = $signed({5'b0, size, 16'b0});
        dlt = neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
        np  = $signed({{2{p[31]}}, p}) + dlt;
        if (np < 0) np = np + lim;
        if (np > lim) np = np - lim;
        return np[31:0];
    endfunction

    // body table
    logic [31:0] mem_px [MAX_BODIES];
    logic [31:0] mem_py [MAX_BODIES];
    logic [31:0] mem_vx [MAX_BODIES];
    logic [31:0] mem_vy [MAX_BODIES];
    logic [31:0] mem_m  [MAX_BODIES];
    logic [31:0] rd_px_reg, rd_py_reg, rd_vx_reg, rd_vy_reg, rd_m_reg;
    logic [IDX_W-1:0] raddr, waddr;
    logic we_pos, we_vel, we_mass;
    logic [31:0] wd_px, wd_py, wd_vx, wd_vy;

    nbgs_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, count_reg, count_next;
    logic [16:0] dt_reg, dt_next;
    logic [12:0] width_reg, width_next, height_reg, height_next;
    logic [31:0] xi_reg, xi_next, yi_reg, yi_next, vxi_reg, vxi_next, vyi_reg, vyi_next;
    logic [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0] mass_reg, mass_next;
    logic [63:0] sq_reg, sq_next, d2_reg, d2_next;
    logic [63:0] sv_reg, sv_next, sr_reg, sr_next, sbit_reg, sbit_next;
    logic [32:0] dist_reg, dist_next;
    logic [35:0] force_reg, force_next;
    logic [15:0] uxm_reg, uxm_next, uym_reg, uym_next;
    logic [47:0] accx_reg, accx_next, accy_reg, accy_next;
    logic [31:0] vxn_reg, vxn_next, pxn_reg, pxn_next;
    logic [47:0] mul_a_reg, mul_a_next;
    logic [31:0] mul_b_reg, mul_b_next;
    logic        mul_ph_reg, mul_ph_next;
    logic [79:0] prod_reg, prod_next;
    logic [55:0] div_num_reg, div_num_next;
    logic [48:0] div_den_reg, div_den_next, div_rem_reg, div_rem_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    nbgs_pkg::out_item_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    // shared units
    logic [31:0] mul_x;
    logic [63:0] mul_out;
    logic [49:0] div_trial;
    logic        div_ge;
    logic [63:0] sq_sum;
    logic [64:0] d2_sum;
    logic [32:0] dx_c, dy_c;
    logic [47:0] termx, termy;
    logic        cfg_we;

    assign mul_x     = mul_ph_reg ? {16'b0, mul_a_reg[47:32]} : mul_a_reg[31:0];
    assign mul_out   = 64'(mul_x) * 64'(mul_b_reg);
    assign div_trial = {div_rem_reg, div_num_reg[55]};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};
    assign sq_sum    = sr_reg + sbit_reg;
    assign d2_sum    = {1'b0, sq_reg} + {1'b0, prod_reg[63:0]};
    assign dx_c      = {rd_px_reg[31], rd_px_reg} - {xi_reg[31], xi_reg};
    assign dy_c      = {rd_py_reg[31], rd_py_reg} - {yi_reg[31], yi_reg};
    assign termx     = dx_reg[32] ? (~{13'b0, prod_reg[50:16]} + 48'd1)
                                  : {13'b0, prod_reg[50:16]};
    assign termy     = dy_reg[32] ? (~{13'b0, prod_reg[50:16]} + 48'd1)
                                  : {13'b0, prod_reg[50:16]};

    assign s_ready = (state_reg == nbgs_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == nbgs_pkg::REG_HEIGHT) ? {19'b0, height_reg}
                                                       : {19'b0, width_reg};

    assign raddr = (state_reg == nbgs_pkg::S_LD_J) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign waddr = (state_reg == nbgs_pkg::S_IDLE) ? count_reg[IDX_W-1:0]
                                                  : i_reg[IDX_W-1:0];
    assign wd_px = (state_reg == nbgs_pkg::S_IDLE) ? s_data.pos_x : pxn_reg;
    assign wd_py = (state_reg == nbgs_pkg::S_IDLE) ? s_data.pos_y
                 : wrap_pos(yi_reg, vyi_reg[31], prod_reg[47:16], height_reg);
    assign wd_vx = (state_reg == nbgs_pkg::S_IDLE) ? s_data.vel_x : vxn_reg;
    assign wd_vy = (state_reg == nbgs_pkg::S_IDLE) ? s_data.vel_y
                 : vel_upd(vyi_reg, accy_reg[47], prod_reg[57:16]);

    always_ff @(posedge aclk) begin
        if (we_pos) begin
            mem_px[waddr] <= wd_px;
            mem_py[waddr] <= wd_py;
        end
        if (we_vel) begin
            mem_vx[waddr] <= wd_vx;
            mem_vy[waddr] <= wd_vy;
        end
        if (we_mass) begin
            mem_m[waddr] <= s_data.mass;
        end
        rd_px_reg <= mem_px[raddr];
        rd_py_reg <= mem_py[raddr];
        rd_vx_reg <= mem_vx[raddr];
        rd_vy_reg <= mem_vy[raddr];
        rd_m_reg  <= mem_m[raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nbgs_pkg::S_IDLE: begin
                if (s_valid && s_data.command == nbgs_pkg::CMD_STEP && count_reg != '0) begin
                    state_next = nbgs_pkg::S_LD_I;
                end
            end
            nbgs_pkg::S_LD_I:  state_next = nbgs_pkg::S_GET_I;
            nbgs_pkg::S_GET_I: state_next = nbgs_pkg::S_LD_J;
            nbgs_pkg::S_LD_J: begin
                if (j_reg == count_reg) begin
                    state_next = nbgs_pkg::S_VX;
                end else if (j_reg != i_reg) begin
                    state_next = nbgs_pkg::S_GET_J;
                end
            end
            nbgs_pkg::S_GET_J, nbgs_pkg::S_SQX, nbgs_pkg::S_AX, nbgs_pkg::S_AY,
            nbgs_pkg::S_VX, nbgs_pkg::S_VY, nbgs_pkg::S_P_GET, nbgs_pkg::S_P_X: begin
                state_next = nbgs_pkg::S_MUL;
            end
            nbgs_pkg::S_SQY: state_next = nbgs_pkg::S_SQRT;
            nbgs_pkg::S_SQRT: begin
                if (sbit_reg == 64'd1) state_next = nbgs_pkg::S_FORCE;
            end
            nbgs_pkg::S_FORCE, nbgs_pkg::S_UX, nbgs_pkg::S_UY: state_next = nbgs_pkg::S_DIV;
            nbgs_pkg::S_ACC: state_next = nbgs_pkg::S_LD_J;
            nbgs_pkg::S_VW: begin
                state_next = (i_reg + 1'b1 == count_reg) ? nbgs_pkg::S_P_LD
                                                        : nbgs_pkg::S_LD_I;
            end
            nbgs_pkg::S_P_LD: state_next = nbgs_pkg::S_P_GET;
            nbgs_pkg::S_P_Y:  state_next = nbgs_pkg::S_P_OUT;
            nbgs_pkg::S_P_OUT: begin
                if (m_ready) begin
                    state_next = (i_reg + 1'b1 == count_reg) ? nbgs_pkg::S_IDLE
                                                            : nbgs_pkg::S_P_LD;
                end
            end
            nbgs_pkg::S_MUL: begin
                if (mul_ph_reg) state_next = ret_reg;
            end
            nbgs_pkg::S_DIV: begin
                if (div_cnt_reg == 6'd55) state_next = ret_reg;
            end
            default: state_next = nbgs_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ret_next     = ret_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        count_next   = count_reg;
        dt_next      = dt_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        xi_next      = xi_reg;
        yi_next      = yi_reg;
        vxi_next     = vxi_reg;
        vyi_next     = vyi_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        mass_next    = mass_reg;
        sq_next      = sq_reg;
        d2_next      = d2_reg;
        sv_next      = sv_reg;
        sr_next      = sr_reg;
        sbit_next    = sbit_reg;
        dist_next    = dist_reg;
        force_next   = force_reg;
        uxm_next     = uxm_reg;
        uym_next     = uym_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        vxn_next     = vxn_reg;
        pxn_next     = pxn_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_ph_next  = mul_ph_reg;
        prod_next    = prod_reg;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        div_rem_next = div_rem_reg;
        div_cnt_next = div_cnt_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        we_pos       = 1'b0;
        we_vel       = 1'b0;
        we_mass      = 1'b0;

        if (cfg_we) begin
            if (paddr[2] == nbgs_pkg::REG_HEIGHT) height_next = pwdata[12:0];
            else width_next = pwdata[12:0];
        end

        case (state_reg)
            nbgs_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (s_data.command)
                        nbgs_pkg::CMD_CLEAR: count_next = '0;
                        nbgs_pkg::CMD_ADD: begin
                            if (count_reg < MAX_CNT) begin
                                we_pos     = 1'b1;
                                we_vel     = 1'b1;
                                we_mass    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        nbgs_pkg::CMD_STEP: begin
                            // dt above one counts as one
                            dt_next = (s_data.time_step[16] && s_data.time_step[15:0] != '0)
                                    ? 17'(nbgs_pkg::ONE_Q16) : s_data.time_step;
                            i_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            nbgs_pkg::S_GET_I: begin
                xi_next   = rd_px_reg;
                yi_next   = rd_py_reg;
                vxi_next  = rd_vx_reg;
                vyi_next  = rd_vy_reg;
                accx_next = '0;
                accy_next = '0;
                j_next    = '0;
            end
            nbgs_pkg::S_LD_J: begin
                if (j_reg != count_reg && j_reg == i_reg) j_next = j_reg + 1'b1;
            end
            nbgs_pkg::S_GET_J: begin
                dx_next     = dx_c;
                dy_next     = dy_c;
                mass_next   = rd_m_reg;
                mul_a_next  = {16'b0, abs33(dx_c)};
                mul_b_next  = abs33(dx_c);
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_SQX;
            end
            nbgs_pkg::S_SQX: begin
                sq_next     = prod_reg[63:0];
                mul_a_next  = {16'b0, abs33(dy_reg)};
                mul_b_next  = abs33(dy_reg);
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_SQY;
            end
            nbgs_pkg::S_SQY: begin
                d2_next   = d2_sum[64] ? '1 : d2_sum[63:0];
                sv_next   = d2_sum[64] ? '1 : d2_sum[63:0];
                sr_next   = '0;
                sbit_next = 64'h4000_0000_0000_0000;
            end
            nbgs_pkg::S_SQRT: begin
                if (sv_reg >= sq_sum) begin
                    sv_next = sv_reg - sq_sum;
                    sr_next = (sr_reg >> 1) + sbit_reg;
                end else begin
                    sr_next = sr_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
            end
            nbgs_pkg::S_FORCE: begin
                dist_next    = {1'b0, sr_reg[31:0]} + 33'(nbgs_pkg::EPS_Q16);
                div_num_next = {40'(mass_reg) * 40'(nbgs_pkg::GRAV_CONST), 16'b0};
                div_den_next = {1'b0, d2_reg[63:16]} + 49'(nbgs_pkg::SOFT_Q16);
                div_rem_next = '0;
                div_cnt_next = '0;
                ret_next     = nbgs_pkg::S_UX;
            end
            nbgs_pkg::S_UX: begin
                force_next   = div_num_reg[35:0];
                div_num_next = {8'b0, abs33(dx_reg), 16'b0};
                div_den_next = {16'b0, dist_reg};
                div_rem_next = '0;
                div_cnt_next = '0;
                ret_next     = nbgs_pkg::S_UY;
            end
            nbgs_pkg::S_UY: begin
                uxm_next     = div_num_reg[15:0];
                div_num_next = {8'b0, abs33(dy_reg), 16'b0};
                div_den_next = {16'b0, dist_reg};
                div_rem_next = '0;
                div_cnt_next = '0;
                ret_next     = nbgs_pkg::S_AX;
            end
            nbgs_pkg::S_AX: begin
                uym_next    = div_num_reg[15:0];
                mul_a_next  = {12'b0, force_reg};
                mul_b_next  = {16'b0, uxm_reg};
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_AY;
            end
            nbgs_pkg::S_AY: begin
                accx_next   = accx_reg + termx;
                mul_a_next  = {12'b0, force_reg};
                mul_b_next  = {16'b0, uym_reg};
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_ACC;
            end
            nbgs_pkg::S_ACC: begin
                accy_next = accy_reg + termy;
                j_next    = j_reg + 1'b1;
            end
            nbgs_pkg::S_VX: begin
                mul_a_next  = abs48(accx_reg);
                mul_b_next  = {15'b0, dt_reg};
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_VY;
            end
            nbgs_pkg::S_VY: begin
                vxn_next    = vel_upd(vxi_reg, accx_reg[47], prod_reg[57:16]);
                mul_a_next  = abs48(accy_reg);
                mul_b_next  = {15'b0, dt_reg};
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_VW;
            end
            nbgs_pkg::S_VW: begin
                we_vel = 1'b1;
                i_next = (i_reg + 1'b1 == count_reg) ? '0 : i_reg + 1'b1;
            end
            nbgs_pkg::S_P_GET: begin
                xi_next     = rd_px_reg;
                yi_next     = rd_py_reg;
                vxi_next    = rd_vx_reg;
                vyi_next    = rd_vy_reg;
                mul_a_next  = {16'b0, abs33({rd_vx_reg[31], rd_vx_reg})};
                mul_b_next  = {15'b0, dt_reg};
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_P_X;
            end
            nbgs_pkg::S_P_X: begin
                pxn_next    = wrap_pos(xi_reg, vxi_reg[31], prod_reg[47:16], width_reg);
                mul_a_next  = {16'b0, abs33({vyi_reg[31], vyi_reg})};
                mul_b_next  = {15'b0, dt_reg};
                mul_ph_next = 1'b0;
                ret_next    = nbgs_pkg::S_P_Y;
            end
            nbgs_pkg::S_P_Y: begin
                we_pos              = 1'b1;
                out_next.body_index = 4'(i_reg);
                out_next.out_pos_x  = pxn_reg;
                out_next.out_pos_y  = wd_py;
                out_next.out_vel_x  = vxi_reg;
                out_next.out_vel_y  = vyi_reg;
                out_next.last       = (i_reg + 1'b1 == count_reg);
                m_valid_next        = 1'b1;
            end
            nbgs_pkg::S_P_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    i_next       = i_reg + 1'b1;
                end
            end
            nbgs_pkg::S_MUL: begin
                if (!mul_ph_reg) begin
                    prod_next   = 80'(mul_out);
                    mul_ph_next = 1'b1;
                end else begin
                    prod_next = prod_reg + {mul_out[47:0], 32'b0};
                end
            end
            nbgs_pkg::S_DIV: begin
                div_rem_next = div_ge ? 49'(div_trial - {1'b0, div_den_reg}) : div_trial[48:0];
                div_num_next = {div_num_reg[54:0], div_ge};
                div_cnt_next = div_cnt_reg + 6'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nbgs_pkg::S_IDLE;
            ret_reg     <= nbgs_pkg::S_IDLE;
            count_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
            mul_ph_reg  <= 1'b0;
            div_cnt_reg <= '0;
            width_reg   <= nbgs_pkg::WIDTH_RESET;
            height_reg  <= nbgs_pkg::HEIGHT_RESET;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            count_reg   <= count_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
            mul_ph_reg  <= mul_ph_next;
            div_cnt_reg <= div_cnt_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg      <= dt_next;
        xi_reg      <= xi_next;
        yi_reg      <= yi_next;
        vxi_reg     <= vxi_next;
        vyi_reg     <= vyi_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        mass_reg    <= mass_next;
        sq_reg      <= sq_next;
        d2_reg      <= d2_next;
        sv_reg      <= sv_next;
        sr_reg      <= sr_next;
        sbit_reg    <= sbit_next;
        dist_reg    <= dist_next;
        force_reg   <= force_next;
        uxm_reg     <= uxm_next;
        uym_reg     <= uym_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        vxn_reg     <= vxn_next;
        pxn_reg     <= pxn_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        prod_reg    <= prod_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        out_reg     <= out_next;
    end

    `NBGS_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= MAX_CNT, "body count overflow")
    `NBGS_ASSERT_IMP(a_out_state, aclk, aresetn, m_valid_reg, state_reg == nbgs_pkg::S_P_OUT, "result shown outside output wait")
    `NBGS_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid_reg && m_ready && out_reg.last, state_reg == nbgs_pkg::S_IDLE, "step did not end after last body")
    `NBGS_ASSERT_IMP(a_div_den, aclk, aresetn, state_reg == nbgs_pkg::S_DIV, div_den_reg != '0, "divide by zero")

endmodule

### tb/nbody_gravity_step_top_tb.sv
// Testbench for the n-body gravity step block: directed table, random command sequences.
`timescale 1ns / 100ps

module nbody_gravity_step_top_tb;

    localparam int NBODY     = 16;
    localparam int WDOG_MAX  = 400000;
    localparam int SETTLE    = 40;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    nbgs_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    nbgs_pkg::out_item_t m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    nbody_gravity_step_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // mirror of the body table and screen size
    logic [31:0] body_px [NBODY];
    logic [31:0] body_py [NBODY];
    logic [31:0] body_vx [NBODY];
    logic [31:0] body_vy [NBODY];
    logic [31:0] body_m  [NBODY];
    int          body_cnt;
    logic [12:0] scr_w;
    logic [12:0] scr_h;

    nbgs_pkg::out_item_t body_reports[$];
    int          n_err;
    int          n_reports;
    int          n_steps;
    int          n_items;
    int          wdog;
    int          tx_idle;
    int          rx_idle;

    typedef struct {
        nbgs_pkg::cmd_t      cmd;
        logic [31:0]         px, py, vx, vy, m;
        logic [16:0]         dt;
        bit                  typed;
        nbgs_pkg::out_item_t want;
    } dir_row_t;

    localparam nbgs_pkg::out_item_t NO_RES = '0;

    dir_row_t dir_rows [12] = '{
        '{nbgs_pkg::CMD_STEP,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h10000, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_ADD,   32'h0064_0000, 32'h0032_0000, 32'h0, 32'h0, 32'h0001_0000,
          17'h0, 1'b0, NO_RES},
        // lone body at rest stays put
        '{nbgs_pkg::CMD_STEP,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h10000, 1'b1,
          '{4'd0, 32'sh0064_0000, 32'sh0032_0000, 32'sh0, 32'sh0, 1'b1}},
        '{nbgs_pkg::CMD_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 17'h1FFFF, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'hFFFF_FFFF, 17'h0, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_ADD,   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'hFFFF_FFFF, 17'h1FFFF, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_ADD,   32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0, 1'b0, NO_RES},
        // dt above one is clamped
        '{nbgs_pkg::CMD_STEP,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h1FFFF, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_STEP,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_STEP,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h08000, 1'b0, NO_RES},
        '{nbgs_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0, 1'b0, NO_RES}
    };

    function automatic longint sx32(logic [31:0] u);
        return longint'($signed(u));
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [31:0] move_wrap(logic [31:0] p, logic [31:0] v, longint dt,
                                              logic [12:0] size);
        longint lim;
        longint np;
        lim = longint'({51'd0, size}) * 65536;
        np = sx32(p) + sx32(v) * dt / 65536;
        if (np < 0) np = np + lim;
        if (np > lim) np = np - lim;
        return np[31:0];
    endfunction

    // gravity sum on old positions, then velocity, then wrapped position
    function automatic void run_gravity(input longint dt, ref nbgs_pkg::out_item_t res[$]);
        longint ax [NBODY];
        longint ay [NBODY];
        longint dx, dy, ux, uy, pull;
        longint unsigned adx, ady, sqx, sqy, d2, dist_q, den;
        nbgs_pkg::out_item_t r;
        for (int i = 0; i < body_cnt; i++) begin
            ax[i] = 0;
            ay[i] = 0;
            for (int j = 0; j < body_cnt; j++) begin
                if (i != j) begin
                    dx = sx32(body_px[j]) - sx32(body_px[i]);
                    dy = sx32(body_py[j]) - sx32(body_py[i]);
                    adx = (dx < 0) ? -dx : dx;
                    ady = (dy < 0) ? -dy : dy;
                    sqx = adx * adx;
                    sqy = ady * ady;
                    d2 = (sqx > ~64'd0 - sqy) ? ~64'd0 : sqx + sqy;
                    dist_q = isqrt(d2) + 64'd66;
                    den = (d2 >> 16) + 64'd1638400;
                    pull = longint'((64'd200 * {32'd0, body_m[j]} * 64'd65536) / den);
                    ux = dx * 65536 / longint'(dist_q);
                    uy = dy * 65536 / longint'(dist_q);
                    ax[i] += pull * ux / 65536;
                    ay[i] += pull * uy / 65536;
                end
            end
        end
        for (int i = 0; i < body_cnt; i++) begin
            body_vx[i] = sat32(sx32(body_vx[i]) + ax[i] * dt / 65536);
            body_vy[i] = sat32(sx32(body_vy[i]) + ay[i] * dt / 65536);
        end
        for (int i = 0; i < body_cnt; i++) begin
            body_px[i] = move_wrap(body_px[i], body_vx[i], dt, scr_w);
            body_py[i] = move_wrap(body_py[i], body_vy[i], dt, scr_h);
            r.body_index = i[3:0];
            r.out_pos_x  = body_px[i];
            r.out_pos_y  = body_py[i];
            r.out_vel_x  = body_vx[i];
            r.out_vel_y  = body_vy[i];
            r.last       = (i + 1 == body_cnt);
            res.push_back(r);
        end
    endfunction

    function automatic void apply_cmd(input nbgs_pkg::in_item_t it,
                                      ref nbgs_pkg::out_item_t res[$]);
        longint dt;
        case (nbgs_pkg::cmd_t'(it.command))
            nbgs_pkg::CMD_CLEAR: body_cnt = 0;
            nbgs_pkg::CMD_ADD: begin
                if (body_cnt < NBODY) begin
                    body_px[body_cnt] = it.pos_x;
                    body_py[body_cnt] = it.pos_y;
                    body_vx[body_cnt] = it.vel_x;
                    body_vy[body_cnt] = it.vel_y;
                    body_m[body_cnt]  = it.mass;
                    body_cnt++;
                end
            end
            nbgs_pkg::CMD_STEP: begin
                if (body_cnt > 0) begin
                    dt = longint'({47'd0, it.time_step});
                    if (dt > 65536) dt = 65536;
                    run_gravity(dt, res);
                end
            end
            default: ;
        endcase
    endfunction

    // one transaction on the command channel; prediction at acceptance
    task automatic send_cmd(input nbgs_pkg::in_item_t it, input bit typed,
                            input nbgs_pkg::out_item_t want);
        nbgs_pkg::out_item_t res[$];
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        apply_cmd(it, res);
        if (it.command == nbgs_pkg::CMD_STEP && res.size() > 0) n_steps++;
        if (typed) body_reports.push_back(want);
        else foreach (res[k]) body_reports.push_back(res[k]);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (body_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == nbgs_pkg::REG_WIDTH) scr_w = val[12:0];
        else scr_h = val[12:0];
    endtask

    function automatic nbgs_pkg::in_item_t rand_body(input nbgs_pkg::cmd_t c);
        nbgs_pkg::in_item_t it;
        int unsigned span;
        span = (scr_w == 0) ? 800 : scr_w;
        it.command   = c;
        it.pos_x     = $urandom_range(0, span * 65536);
        span = (scr_h == 0) ? 600 : scr_h;
        it.pos_y     = $urandom_range(0, span * 65536);
        it.vel_x     = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        it.vel_y     = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        it.mass      = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
        it.time_step = ($urandom_range(7) == 0) ? 17'($urandom_range(0, 17'h1FFFF))
                                                : 17'($urandom_range(0, 17'h10000));
        return it;
    endfunction

    function automatic nbgs_pkg::in_item_t rand_noise();
        nbgs_pkg::in_item_t it;
        it.command   = 2'($urandom_range(0, 3));
        it.pos_x     = $urandom;
        it.pos_y     = $urandom;
        it.vel_x     = $urandom;
        it.vel_y     = $urandom;
        it.mass      = $urandom;
        it.time_step = 17'($urandom_range(0, 17'h1FFFF));
        return it;
    endfunction

    // clear, a run of adds, a few steps, with noise mixed in
    task automatic run_sequence(input int n_add);
        nbgs_pkg::in_item_t it;
        int n_step;
        send_cmd(rand_body(nbgs_pkg::CMD_CLEAR), 1'b0, NO_RES);
        for (int k = 0; k < n_add; k++) begin
            if ($urandom_range(9) == 0) send_cmd(rand_noise(), 1'b0, NO_RES);
            send_cmd(rand_body(nbgs_pkg::CMD_ADD), 1'b0, NO_RES);
        end
        n_step = $urandom_range(1, 3);
        for (int k = 0; k < n_step; k++) begin
            it = rand_body(nbgs_pkg::CMD_STEP);
            send_cmd(it, 1'b0, NO_RES);
            if ($urandom_range(4) == 0) send_cmd(rand_body(nbgs_pkg::CMD_NOP), 1'b0, NO_RES);
        end
    endtask

    // result checking and watchdog
    always @(posedge aclk) begin
        nbgs_pkg::out_item_t want;
        if (aresetn) begin
            if ((m_valid && m_ready) || (s_valid && s_ready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("%0t: no transaction for %0d cycles", $time, WDOG_MAX);
                $display("simulation failed");
                $finish;
            end
        end
        if (m_valid && m_ready) begin
            n_reports++;
            if (body_reports.size() == 0) begin
                $display("%0t: unexpected result: actual %p", $time, m_data);
                n_err++;
            end else begin
                want = body_reports.pop_front();
                if (m_data.body_index !== want.body_index) begin
                    $display("%0t: body_index expected %0d actual %0d", $time,
                             want.body_index, m_data.body_index);
                    n_err++;
                end
                if (m_data.out_pos_x !== want.out_pos_x) begin
                    $display("%0t: out_pos_x expected %h actual %h", $time,
                             want.out_pos_x, m_data.out_pos_x);
                    n_err++;
                end
                if (m_data.out_pos_y !== want.out_pos_y) begin
                    $display("%0t: out_pos_y expected %h actual %h", $time,
                             want.out_pos_y, m_data.out_pos_y);
                    n_err++;
                end
                if (m_data.out_vel_x !== want.out_vel_x) begin
                    $display("%0t: out_vel_x expected %h actual %h", $time,
                             want.out_vel_x, m_data.out_vel_x);
                    n_err++;
                end
                if (m_data.out_vel_y !== want.out_vel_y) begin
                    $display("%0t: out_vel_y expected %h actual %h", $time,
                             want.out_vel_y, m_data.out_vel_y);
                    n_err++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, m_data.last);
                    n_err++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= rx_idle);
    end

    initial begin
        nbgs_pkg::in_item_t it;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        body_cnt  = 0;
        scr_w     = nbgs_pkg::WIDTH_RESET;
        scr_h     = nbgs_pkg::HEIGHT_RESET;
        n_err     = 0;
        n_reports = 0;
        n_steps   = 0;
        n_items   = 0;
        wdog      = 0;
        tx_idle   = 10;
        rx_idle   = 86;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, screen at its reset size
        foreach (dir_rows[r]) begin
            it.command   = dir_rows[r].cmd;
            it.pos_x     = dir_rows[r].px;
            it.pos_y     = dir_rows[r].py;
            it.vel_x     = dir_rows[r].vx;
            it.vel_y     = dir_rows[r].vy;
            it.mass      = dir_rows[r].m;
            it.time_step = dir_rows[r].dt;
            send_cmd(it, dir_rows[r].typed, dir_rows[r].want);
        end

        // random part in three idling phases, new screen size for each
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: begin
                    apb_write(nbgs_pkg::REG_WIDTH, 32'd1 | ($urandom & 32'hFFFF_E000));
                    apb_write(nbgs_pkg::REG_HEIGHT, 32'd4096);
                end
                1: begin
                    tx_idle = 86;
                    rx_idle = 10;
                    apb_write(nbgs_pkg::REG_WIDTH, 32'd0);
                    apb_write(nbgs_pkg::REG_HEIGHT, 32'h1FFF | ($urandom & 32'hFFFF_E000));
                end
                default: begin
                    tx_idle = 0;
                    rx_idle = 0;
                    apb_write(nbgs_pkg::REG_WIDTH, $urandom_range(1, 4096));
                    apb_write(nbgs_pkg::REG_HEIGHT, $urandom_range(1, 4096));
                end
            endcase
            // a full table, with adds past the end ignored
            if (ph == 0) run_sequence(NBODY + 2);
            while (n_items < 12 + 35 * (ph + 1)) begin
                if ($urandom_range(3) == 0) drain();
                run_sequence(($urandom_range(11) == 0) ? $urandom_range(5, 8)
                                                      : $urandom_range(1, 4));
            end
        end
        drain();

        $display("%0d commands sent, %0d steps with bodies, %0d body reports checked",
                 n_items, n_steps, n_reports);
        $display("screen sizes: reset, extremes 0/1/4096/8191 and random");
        if (n_err == 0 && body_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d reports outstanding", n_err, body_reports.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### nbody_gravity_step_top.f
+incdir+rtl
rtl/nbgs_pkg.sv
rtl/nbody_gravity_step_top.sv
tb/nbody_gravity_step_top_tb.sv
